@@ rtl/rvdec_pkg.sv @@
// ----------------------------------------------------------------------------
// RV32I instruction decoder package
// Transaction types, major opcodes and operation codes shared by the decoder.
// ----------------------------------------------------------------------------
package rvdec_pkg;

  localparam int XLEN = 32;

  typedef struct packed {
    logic [XLEN-1:0] instruction;
    logic [XLEN-1:0] pc_address;
  } item_t;

  typedef struct packed {
    logic [5:0]             op_code;
    logic [4:0]             dest_reg;
    logic [4:0]             src1_reg;
    logic [4:0]             src2_reg;
    logic signed [XLEN-1:0] immediate;
    logic [XLEN-1:0]        target_address;
    logic [11:0]            csr_number;
  } result_t;

  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_ALUI   = 7'h13;
  localparam logic [6:0] OPC_ALUR   = 7'h33;
  localparam logic [6:0] OPC_SYS    = 7'h73;

  localparam logic [6:0] F7_ZERO = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [XLEN-1:0] WORD_ECALL  = 32'h0000_0073;
  localparam logic [XLEN-1:0] WORD_EBREAK = 32'h0010_0073;

  localparam logic [5:0] OP_ILLEGAL = 6'd0;
  localparam logic [5:0] OP_LUI     = 6'd1;
  localparam logic [5:0] OP_AUIPC   = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_JALR    = 6'd4;
  localparam logic [5:0] OP_BEQ     = 6'd5;
  localparam logic [5:0] OP_BNE     = 6'd6;
  localparam logic [5:0] OP_BLT     = 6'd7;
  localparam logic [5:0] OP_BGE     = 6'd8;
  localparam logic [5:0] OP_BLTU    = 6'd9;
  localparam logic [5:0] OP_BGEU    = 6'd10;
  localparam logic [5:0] OP_LB      = 6'd11;
  localparam logic [5:0] OP_LH      = 6'd12;
  localparam logic [5:0] OP_LW      = 6'd13;
  localparam logic [5:0] OP_LBU     = 6'd14;
  localparam logic [5:0] OP_LHU     = 6'd15;
  localparam logic [5:0] OP_SB      = 6'd16;
  localparam logic [5:0] OP_SH      = 6'd17;
  localparam logic [5:0] OP_SW      = 6'd18;
  localparam logic [5:0] OP_ADDI    = 6'd19;
  localparam logic [5:0] OP_SLLI    = 6'd20;
  localparam logic [5:0] OP_SLTI    = 6'd21;
  localparam logic [5:0] OP_SLTIU   = 6'd22;
  localparam logic [5:0] OP_XORI    = 6'd23;
  localparam logic [5:0] OP_SRLI    = 6'd24;
  localparam logic [5:0] OP_SRAI    = 6'd25;
  localparam logic [5:0] OP_ORI     = 6'd26;
  localparam logic [5:0] OP_ANDI    = 6'd27;
  localparam logic [5:0] OP_ADD     = 6'd28;
  localparam logic [5:0] OP_SUB     = 6'd29;
  localparam logic [5:0] OP_SLL     = 6'd30;
  localparam logic [5:0] OP_SLT     = 6'd31;
  localparam logic [5:0] OP_SLTU    = 6'd32;
  localparam logic [5:0] OP_XOR     = 6'd33;
  localparam logic [5:0] OP_SRL     = 6'd34;
  localparam logic [5:0] OP_SRA     = 6'd35;
  localparam logic [5:0] OP_OR      = 6'd36;
  localparam logic [5:0] OP_AND     = 6'd37;
  localparam logic [5:0] OP_CSRRW   = 6'd38;
  localparam logic [5:0] OP_CSRRS   = 6'd39;
  localparam logic [5:0] OP_CSRRC   = 6'd40;
  localparam logic [5:0] OP_CSRRWI  = 6'd41;
  localparam logic [5:0] OP_CSRRSI  = 6'd42;
  localparam logic [5:0] OP_CSRRCI  = 6'd43;
  localparam logic [5:0] OP_ECALL   = 6'd44;
  localparam logic [5:0] OP_EBREAK  = 6'd45;

endpackage

@@ rtl/rv32i_instruction_decoder_top.sv @@
// ----------------------------------------------------------------------------
// RV32I instruction decoder, top level
// Registers each instruction, decodes it and registers the result.
// ----------------------------------------------------------------------------
// One instruction is taken in every cycle that start is high, since busy is
// never raised. Its result appears on the result port, marked by done, after
// passing through the input register and then through the decode logic into
// the result register. Each result is shown for exactly one cycle and the
// receiver must take it then.
module rv32i_instruction_decoder_top
  import rvdec_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result
);

  logic    stage_valid;
  item_t   stage_item;
  result_t decoded;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      done        <= 1'b0;
    end else begin
      stage_valid <= start && !busy;
      done        <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      stage_item <= item;
    end
    if (stage_valid) begin
      result <= decoded;
    end
  end

  rvdec_decode u_decode (
    .item   (stage_item),
    .result (decoded)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("Accepted transaction gave no result two cycles later.");

  assert property (@(posedge clk) disable iff (rst)
    (done && result.target_address != '0) |->
      (result.op_code == OP_JAL || result.op_code == OP_BEQ ||
       result.op_code == OP_BNE || result.op_code == OP_BLT ||
       result.op_code == OP_BGE || result.op_code == OP_BLTU ||
       result.op_code == OP_BGEU))
    else $error("Target address set for an operation that is not a jump or branch.");

  assert property (@(posedge clk) disable iff (rst)
    (done && result.csr_number != 12'd0) |->
      (result.op_code >= OP_CSRRW && result.op_code <= OP_CSRRCI))
    else $error("CSR number set for an operation that is not a CSR access.");
`endif

endmodule

@@ rtl/rvdec_decode.sv @@
// ----------------------------------------------------------------------------
// RV32I decode logic
// Classifies one instruction word and forms its immediate, branch or jump
// target and CSR number.
// ----------------------------------------------------------------------------
module rvdec_decode
  import rvdec_pkg::*;
(
  input  item_t   item,
  output result_t result
);

  logic [XLEN-1:0] w;
  logic [6:0]      opc;
  logic [2:0]      f3;
  logic [6:0]      f7;
  logic [XLEN-1:0] imm_i;
  logic [XLEN-1:0] imm_s;
  logic [XLEN-1:0] imm_b;
  logic [XLEN-1:0] imm_j;
  logic [XLEN-1:0] imm_u;
  logic [XLEN-1:0] imm_sh;
  logic [XLEN-1:0] imm_z;
  logic [5:0]      op;
  logic [XLEN-1:0] imm;
  logic            use_tgt;
  logic            use_csr;

  assign w   = item.instruction;
  assign opc = w[6:0];
  assign f3  = w[14:12];
  assign f7  = w[31:25];

  assign imm_i  = {{20{w[31]}}, w[31:20]};
  assign imm_s  = {{20{w[31]}}, w[31:25], w[11:7]};
  assign imm_b  = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
  assign imm_j  = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
  assign imm_u  = {12'b0, w[31:12]};
  assign imm_sh = {27'b0, w[24:20]};
  assign imm_z  = {27'b0, w[19:15]};

  always_comb begin
    op      = OP_ILLEGAL;
    imm     = '0;
    use_tgt = 1'b0;
    use_csr = 1'b0;
    case (opc)
      OPC_LUI: begin
        op  = OP_LUI;
        imm = imm_u;
      end
      OPC_AUIPC: begin
        op  = OP_AUIPC;
        imm = imm_u;
      end
      OPC_JAL: begin
        op      = OP_JAL;
        imm     = imm_j;
        use_tgt = 1'b1;
      end
      OPC_JALR: begin
        if (f3 == 3'd0) begin
          op  = OP_JALR;
          imm = imm_i;
        end
      end
      OPC_BRANCH: begin
        case (f3)
          3'd0:    op = OP_BEQ;
          3'd1:    op = OP_BNE;
          3'd4:    op = OP_BLT;
          3'd5:    op = OP_BGE;
          3'd6:    op = OP_BLTU;
          3'd7:    op = OP_BGEU;
          default: op = OP_ILLEGAL;
        endcase
        if (op != OP_ILLEGAL) begin
          imm     = imm_b;
          use_tgt = 1'b1;
        end
      end
      OPC_LOAD: begin
        case (f3)
          3'd0:    op = OP_LB;
          3'd1:    op = OP_LH;
          3'd2:    op = OP_LW;
          3'd4:    op = OP_LBU;
          3'd5:    op = OP_LHU;
          default: op = OP_ILLEGAL;
        endcase
        if (op != OP_ILLEGAL) begin
          imm = imm_i;
        end
      end
      OPC_STORE: begin
        case (f3)
          3'd0:    op = OP_SB;
          3'd1:    op = OP_SH;
          3'd2:    op = OP_SW;
          default: op = OP_ILLEGAL;
        endcase
        if (op != OP_ILLEGAL) begin
          imm = imm_s;
        end
      end
      OPC_ALUI: begin
        imm = imm_i;
        case (f3)
          3'd0: op = OP_ADDI;
          3'd1: begin
            imm = '0;
            if (f7 == F7_ZERO) begin
              op  = OP_SLLI;
              imm = imm_sh;
            end
          end
          3'd2: op = OP_SLTI;
          3'd3: op = OP_SLTIU;
          3'd4: op = OP_XORI;
          3'd5: begin
            imm = '0;
            if (f7 == F7_ZERO) begin
              op  = OP_SRLI;
              imm = imm_sh;
            end else if (f7 == F7_ALT) begin
              op  = OP_SRAI;
              imm = imm_sh;
            end
          end
          3'd6:    op = OP_ORI;
          default: op = OP_ANDI;
        endcase
      end
      OPC_ALUR: begin
        if (f7 == F7_ZERO) begin
          case (f3)
            3'd0:    op = OP_ADD;
            3'd1:    op = OP_SLL;
            3'd2:    op = OP_SLT;
            3'd3:    op = OP_SLTU;
            3'd4:    op = OP_XOR;
            3'd5:    op = OP_SRL;
            3'd6:    op = OP_OR;
            default: op = OP_AND;
          endcase
        end else if (f7 == F7_ALT) begin
          if (f3 == 3'd0) begin
            op = OP_SUB;
          end else if (f3 == 3'd5) begin
            op = OP_SRA;
          end
        end
      end
      OPC_SYS: begin
        if (w == WORD_ECALL) begin
          op = OP_ECALL;
        end else if (w == WORD_EBREAK) begin
          op = OP_EBREAK;
        end else begin
          case (f3)
            3'd1: begin
              op      = OP_CSRRW;
              use_csr = 1'b1;
            end
            3'd2: begin
              op      = OP_CSRRS;
              use_csr = 1'b1;
            end
            3'd3: begin
              op      = OP_CSRRC;
              use_csr = 1'b1;
            end
            3'd5: begin
              op      = OP_CSRRWI;
              use_csr = 1'b1;
              imm     = imm_z;
            end
            3'd6: begin
              op      = OP_CSRRSI;
              use_csr = 1'b1;
              imm     = imm_z;
            end
            3'd7: begin
              op      = OP_CSRRCI;
              use_csr = 1'b1;
              imm     = imm_z;
            end
            default: op = OP_ILLEGAL;
          endcase
        end
      end
      default: op = OP_ILLEGAL;
    endcase
  end

  assign result.op_code        = op;
  assign result.dest_reg       = w[11:7];
  assign result.src1_reg       = w[19:15];
  assign result.src2_reg       = w[24:20];
  assign result.immediate      = imm;
  assign result.target_address = use_tgt ? (item.pc_address + imm) : '0;
  assign result.csr_number     = use_csr ? w[31:20] : 12'd0;

endmodule

@@ dv/rv32i_instruction_decoder_top_tb.sv @@
// ----------------------------------------------------------------------------
// RV32I instruction decoder testbench
// Sends a short table of hand-picked instruction words, then several hundred
// random words, most of them built on real major opcodes with random fields.
// Every decoded result is compared field by field with a behavioural decoder
// held in this file, or with the value typed into the table.
// ----------------------------------------------------------------------------
module rv32i_instruction_decoder_top_tb;
  import rvdec_pkg::*;

  localparam int N_DIRECTED   = 26;
  localparam int N_RANDOM     = 700;
  localparam int STALL_LIMIT  = 1000;
  localparam int IDLE_PERCENT = 12;
  localparam int CALM_FIRST   = 250;
  localparam int CALM_LAST    = 449;
  localparam int DRAIN_AT     = 520;
  localparam int SETTLE       = 4;

  localparam logic [2:0] F3_JALR = 3'd0;

  localparam logic [9:0][6:0] MAJOR_OPCODES = {
    OPC_SYS, OPC_ALUR, OPC_ALUI, OPC_STORE, OPC_LOAD,
    OPC_BRANCH, OPC_JALR, OPC_JAL, OPC_AUIPC, OPC_LUI};

  localparam logic [7:0][5:0] BRANCH_OPS = {
    OP_BGEU, OP_BLTU, OP_BGE, OP_BLT, OP_ILLEGAL, OP_ILLEGAL, OP_BNE, OP_BEQ};
  localparam logic [7:0][5:0] LOAD_OPS = {
    OP_ILLEGAL, OP_ILLEGAL, OP_LHU, OP_LBU, OP_ILLEGAL, OP_LW, OP_LH, OP_LB};
  localparam logic [7:0][5:0] STORE_OPS = {
    OP_ILLEGAL, OP_ILLEGAL, OP_ILLEGAL, OP_ILLEGAL, OP_ILLEGAL, OP_SW, OP_SH, OP_SB};
  localparam logic [7:0][5:0] ALUI_OPS = {
    OP_ANDI, OP_ORI, OP_SRLI, OP_XORI, OP_SLTIU, OP_SLTI, OP_SLLI, OP_ADDI};
  localparam logic [7:0][5:0] ALUR_OPS = {
    OP_AND, OP_OR, OP_SRL, OP_XOR, OP_SLTU, OP_SLT, OP_SLL, OP_ADD};
  localparam logic [7:0][5:0] ALUR_ALT_OPS = {
    OP_ILLEGAL, OP_ILLEGAL, OP_SRA, OP_ILLEGAL, OP_ILLEGAL, OP_ILLEGAL, OP_ILLEGAL, OP_SUB};
  localparam logic [7:0][5:0] SYS_OPS = {
    OP_CSRRCI, OP_CSRRSI, OP_CSRRWI, OP_ILLEGAL, OP_CSRRC, OP_CSRRS, OP_CSRRW, OP_ILLEGAL};

  typedef struct packed {
    logic [31:0] word;
    logic [31:0] pc;
    logic        typed;
    result_t     want;
  } stim_row_t;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  item_t   item;
  logic    done;
  result_t result;

  logic      exp_typed;
  result_t   exp_given;
  result_t   pending_decodes[$];
  result_t   oldest;
  stim_row_t dir_rows [N_DIRECTED];
  int        error_count;
  int        stall_cycles;

  rv32i_instruction_decoder_top u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic result_t decode_instruction(item_t it);
    logic [31:0] w;
    logic [6:0]  opc;
    logic [6:0]  f7;
    logic [2:0]  f3;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    result_t     r;
    w     = it.instruction;
    opc   = w[6:0];
    f3    = w[14:12];
    f7    = w[31:25];
    imm_i = {{20{w[31]}}, w[31:20]};
    imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
    imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    r          = '0;
    r.dest_reg = w[11:7];
    r.src1_reg = w[19:15];
    r.src2_reg = w[24:20];
    case (opc)
      OPC_LUI: begin
        r.op_code   = OP_LUI;
        r.immediate = {12'd0, w[31:12]};
      end
      OPC_AUIPC: begin
        r.op_code   = OP_AUIPC;
        r.immediate = {12'd0, w[31:12]};
      end
      OPC_JAL: begin
        r.op_code        = OP_JAL;
        r.immediate      = imm_j;
        r.target_address = it.pc_address + imm_j;
      end
      OPC_JALR: begin
        if (f3 == F3_JALR) begin
          r.op_code   = OP_JALR;
          r.immediate = imm_i;
        end
      end
      OPC_BRANCH: begin
        r.op_code = BRANCH_OPS[f3];
        if (r.op_code != OP_ILLEGAL) begin
          r.immediate      = imm_b;
          r.target_address = it.pc_address + imm_b;
        end
      end
      OPC_LOAD: begin
        r.op_code = LOAD_OPS[f3];
        if (r.op_code != OP_ILLEGAL) r.immediate = imm_i;
      end
      OPC_STORE: begin
        r.op_code = STORE_OPS[f3];
        if (r.op_code != OP_ILLEGAL) r.immediate = imm_s;
      end
      OPC_ALUI: begin
        r.op_code = ALUI_OPS[f3];
        if (r.op_code == OP_SLLI || r.op_code == OP_SRLI) begin
          if (r.op_code == OP_SRLI && f7 == F7_ALT) r.op_code = OP_SRAI;
          else if (f7 != F7_ZERO) r.op_code = OP_ILLEGAL;
          if (r.op_code != OP_ILLEGAL) r.immediate = {27'd0, w[24:20]};
        end else begin
          r.immediate = imm_i;
        end
      end
      OPC_ALUR: begin
        if (f7 == F7_ZERO) r.op_code = ALUR_OPS[f3];
        else if (f7 == F7_ALT) r.op_code = ALUR_ALT_OPS[f3];
      end
      OPC_SYS: begin
        if (w == WORD_ECALL) begin
          r.op_code = OP_ECALL;
        end else if (w == WORD_EBREAK) begin
          r.op_code = OP_EBREAK;
        end else begin
          r.op_code = SYS_OPS[f3];
          if (r.op_code != OP_ILLEGAL) r.csr_number = w[31:20];
          if (r.op_code >= OP_CSRRWI) r.immediate = {27'd0, w[19:15]};
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Mostly real major opcodes with random fields; the funct7 of the ALU groups
  // is usually forced to a legal value so that shifts and register ops decode.
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    logic [6:0]  major;
    int          pick;
    w    = $urandom;
    pick = $urandom_range(99);
    if (pick < 12) return w;
    major   = MAJOR_OPCODES[$urandom_range(9)];
    w[6:0]  = major;
    if (major == OPC_ALUI || major == OPC_ALUR) begin
      if ($urandom_range(9) < 8) w[31:25] = ($urandom_range(1) == 1) ? F7_ALT : F7_ZERO;
    end else if (major == OPC_SYS) begin
      pick = $urandom_range(9);
      if (pick == 0) w = WORD_ECALL;
      else if (pick == 1) w = WORD_EBREAK;
    end
    return w;
  endfunction

  function automatic logic [31:0] random_pc();
    case ($urandom_range(9))
      0:       return 32'hFFFF_FFFF - $urandom_range(4095);
      1:       return $urandom_range(4095);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_instruction(input logic [31:0] word, input logic [31:0] pc,
                                  input logic typed, input result_t want,
                                  input logic may_idle);
    while (may_idle && $urandom_range(99) < IDLE_PERCENT) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start            <= 1'b1;
    item.instruction <= word;
    item.pc_address  <= pc;
    exp_typed        <= typed;
    exp_given        <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (pending_decodes.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, actual %h", $time, result);
        end else begin
          oldest = pending_decodes.pop_front();
          compare_field("op_code", oldest.op_code, result.op_code);
          compare_field("dest_reg", oldest.dest_reg, result.dest_reg);
          compare_field("src1_reg", oldest.src1_reg, result.src1_reg);
          compare_field("src2_reg", oldest.src2_reg, result.src2_reg);
          compare_field("immediate", oldest.immediate, result.immediate);
          compare_field("target_address", oldest.target_address, result.target_address);
          compare_field("csr_number", oldest.csr_number, result.csr_number);
        end
      end
      if (start && !busy)
        pending_decodes.push_back(exp_typed ? exp_given : decode_instruction(item));
      if ((start && !busy) || done) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    item         = '0;
    exp_typed    = 1'b0;
    exp_given    = '0;
    error_count  = 0;
    stall_cycles = 0;

    dir_rows[0]  = {32'h0000_0000, 32'h0000_0000, 1'b1,
                    OP_ILLEGAL, 5'd0, 5'd0, 5'd0, 32'd0, 32'd0, 12'd0};
    dir_rows[1]  = {32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                    OP_ILLEGAL, 5'd31, 5'd31, 5'd31, 32'd0, 32'd0, 12'd0};
    dir_rows[2]  = {WORD_ECALL, 32'h0000_1000, 1'b1,
                    OP_ECALL, 5'd0, 5'd0, 5'd0, 32'd0, 32'd0, 12'd0};
    dir_rows[3]  = {WORD_EBREAK, 32'h0000_1004, 1'b1,
                    OP_EBREAK, 5'd0, 5'd0, 5'd1, 32'd0, 32'd0, 12'd0};
    dir_rows[4]  = {32'h0020_0073, 32'h0000_1008, 1'b1,
                    OP_ILLEGAL, 5'd0, 5'd0, 5'd2, 32'd0, 32'd0, 12'd0};
    dir_rows[5]  = {32'h0000_4073, 32'h0000_100C, 1'b1,
                    OP_ILLEGAL, 5'd0, 5'd0, 5'd0, 32'd0, 32'd0, 12'd0};
    dir_rows[6]  = {32'hFFFF_F0B7, 32'h0000_0000, 1'b0, result_t'(0)};
    dir_rows[7]  = {32'h0000_1017, 32'h8000_0000, 1'b0, result_t'(0)};
    dir_rows[8]  = {32'h8000_006F, 32'h0000_0000, 1'b0, result_t'(0)};
    dir_rows[9]  = {32'h7FFF_F06F, 32'hFFFF_FF00, 1'b0, result_t'(0)};
    dir_rows[10] = {32'hFFF0_8067, 32'h0000_2000, 1'b0, result_t'(0)};
    dir_rows[11] = {32'h0000_1067, 32'h0000_2004, 1'b1,
                    OP_ILLEGAL, 5'd0, 5'd0, 5'd0, 32'd0, 32'd0, 12'd0};
    dir_rows[12] = {32'h0000_2063, 32'h0000_2008, 1'b1,
                    OP_ILLEGAL, 5'd0, 5'd0, 5'd0, 32'd0, 32'd0, 12'd0};
    dir_rows[13] = {32'h8000_0063, 32'h0000_0000, 1'b0, result_t'(0)};
    dir_rows[14] = {32'h7E00_FFE3, 32'hFFFF_F000, 1'b0, result_t'(0)};
    dir_rows[15] = {32'h0000_3003, 32'h0000_3000, 1'b1,
                    OP_ILLEGAL, 5'd0, 5'd0, 5'd0, 32'd0, 32'd0, 12'd0};
    dir_rows[16] = {32'h8000_4003, 32'h0000_3004, 1'b0, result_t'(0)};
    dir_rows[17] = {32'h0000_3023, 32'h0000_3008, 1'b1,
                    OP_ILLEGAL, 5'd0, 5'd0, 5'd0, 32'd0, 32'd0, 12'd0};
    dir_rows[18] = {32'hFE0F_AFA3, 32'h0000_300C, 1'b0, result_t'(0)};
    dir_rows[19] = {32'h0200_1013, 32'h0000_4000, 1'b1,
                    OP_ILLEGAL, 5'd0, 5'd0, 5'd0, 32'd0, 32'd0, 12'd0};
    dir_rows[20] = {32'h41F0_D093, 32'h0000_4004, 1'b0, result_t'(0)};
    dir_rows[21] = {32'h8000_5013, 32'h0000_4008, 1'b1,
                    OP_ILLEGAL, 5'd0, 5'd0, 5'd0, 32'd0, 32'd0, 12'd0};
    dir_rows[22] = {32'h4000_4033, 32'h0000_400C, 1'b1,
                    OP_ILLEGAL, 5'd0, 5'd0, 5'd0, 32'd0, 32'd0, 12'd0};
    dir_rows[23] = {32'h0200_0033, 32'h0000_4010, 1'b1,
                    OP_ILLEGAL, 5'd0, 5'd0, 5'd0, 32'd0, 32'd0, 12'd0};
    dir_rows[24] = {32'hFFFF_F073, 32'h0000_5000, 1'b0, result_t'(0)};
    dir_rows[25] = {32'h7FF0_0013, 32'h0000_5004, 1'b0, result_t'(0)};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++)
      send_instruction(dir_rows[i].word, dir_rows[i].pc, dir_rows[i].typed,
                       dir_rows[i].want, 1'b1);

    for (int i = 0; i < N_RANDOM; i++) begin
      // Hold off once until the decoder has delivered every transaction.
      if (i == DRAIN_AT) begin
        start <= 1'b0;
        @(negedge clk);
        while (pending_decodes.size() != 0) @(negedge clk);
      end
      send_instruction(random_word(), random_pc(), 1'b0, result_t'(0),
                       !(i >= CALM_FIRST && i <= CALM_LAST));
    end

    start <= 1'b0;
    while (pending_decodes.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
